// ===== hdl/segment_intersection_defines.svh =====
// ---------------------------------------------------------------------------
// Segment intersection assertion macros
// Shared assertion forms for the checker of the segment intersection block.
// ---------------------------------------------------------------------------
`ifndef SEGMENT_INTERSECTION_DEFINES_SVH
`define SEGMENT_INTERSECTION_DEFINES_SVH

// check a property outside of reset
`define SGI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check a property at every edge, reset included
`define SGI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/sgi_pkg.sv =====
// ---------------------------------------------------------------------------
// Segment intersection package
// Widths and the control struct shared by the pipeline modules.
// ---------------------------------------------------------------------------
`default_nettype none

package sgi_pkg;

  localparam int COORD_BITS = 16;
  localparam int DB  = COORD_BITS + 1;        // coordinate difference
  localparam int PB  = 2 * DB;                // difference product
  localparam int XB  = PB + 1;                // cross product
  localparam int AB  = XB;                    // cross product magnitude
  localparam int WB  = AB + COORD_BITS + 1;   // weighted coordinate
  localparam int NB  = WB + 1;                // numerator
  localparam int DNB = AB + 1;                // denominator
  localparam int QB  = COORD_BITS + 1;        // quotient magnitude
  localparam int RB  = (NB > DNB + QB) ? NB : DNB + QB;

  typedef struct packed {
    logic valid;
    logic meets;
    logic point_valid;
  } sgi_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/sgi_cross.sv =====
// ---------------------------------------------------------------------------
// Segment intersection cross-product stages
// Three stages: differences and box test, products, cross products and
// straddle tests with the weighting areas.
// ---------------------------------------------------------------------------
`default_nettype none

module sgi_cross (
  input  wire                                       clk,
  input  wire                                       rst,
  input  wire                                       en,
  input  wire                                       in_valid,
  input  wire logic signed [sgi_pkg::COORD_BITS-1:0] x1,
  input  wire logic signed [sgi_pkg::COORD_BITS-1:0] y1,
  input  wire logic signed [sgi_pkg::COORD_BITS-1:0] x2,
  input  wire logic signed [sgi_pkg::COORD_BITS-1:0] y2,
  input  wire logic signed [sgi_pkg::COORD_BITS-1:0] x3,
  input  wire logic signed [sgi_pkg::COORD_BITS-1:0] y3,
  input  wire logic signed [sgi_pkg::COORD_BITS-1:0] x4,
  input  wire logic signed [sgi_pkg::COORD_BITS-1:0] y4,
  output sgi_pkg::sgi_ctl_t                         ctl,
  output logic [sgi_pkg::AB-1:0]                    a3,
  output logic [sgi_pkg::AB-1:0]                    a4,
  output logic signed [sgi_pkg::COORD_BITS-1:0]     bx3,
  output logic signed [sgi_pkg::COORD_BITS-1:0]     by3,
  output logic signed [sgi_pkg::COORD_BITS-1:0]     bx4,
  output logic signed [sgi_pkg::COORD_BITS-1:0]     by4
);
  import sgi_pkg::*;

  logic signed [COORD_BITS-1:0] ax_lo, ax_hi, ay_lo, ay_hi;
  logic signed [COORD_BITS-1:0] bx_lo, bx_hi, by_lo, by_hi;
  logic                         box_next;

  logic                  v1, box1;
  logic signed [DB-1:0]  dx21, dy21, dx31, dy31, dx41, dy41;
  logic signed [DB-1:0]  dx43, dy43, dx13, dy13, dx23, dy23;
  logic signed [COORD_BITS-1:0] s1x3, s1y3, s1x4, s1y4;

  logic                  v2, box2;
  logic signed [PB-1:0]  p3a, p3b, p4a, p4b, pe1a, pe1b, pe2a, pe2b;
  logic signed [COORD_BITS-1:0] s2x3, s2y3, s2x4, s2y4;

  logic signed [XB-1:0]  c3, c4, e1, e2;
  logic                  st1, st2;

  always_comb begin
    ax_lo = (x1 < x2) ? x1 : x2;
    ax_hi = (x1 < x2) ? x2 : x1;
    ay_lo = (y1 < y2) ? y1 : y2;
    ay_hi = (y1 < y2) ? y2 : y1;
    bx_lo = (x3 < x4) ? x3 : x4;
    bx_hi = (x3 < x4) ? x4 : x3;
    by_lo = (y3 < y4) ? y3 : y4;
    by_hi = (y3 < y4) ? y4 : y3;
    box_next = (ax_lo <= bx_hi) && (bx_lo <= ax_hi) &&
               (ay_lo <= by_hi) && (by_lo <= ay_hi);
  end

  always_comb begin
    c3  = XB'(p3a) - XB'(p3b);
    c4  = XB'(p4a) - XB'(p4b);
    e1  = XB'(pe1a) - XB'(pe1b);
    e2  = XB'(pe2a) - XB'(pe2b);
    st1 = (e1 == '0) || (e2 == '0) || (e1[XB-1] == e2[XB-1]);
    st2 = (c3 == '0) || (c4 == '0) || (c3[XB-1] != c4[XB-1]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      ctl.valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      ctl.valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      box1 <= box_next;
      dx21 <= DB'(x2) - DB'(x1);
      dy21 <= DB'(y2) - DB'(y1);
      dx31 <= DB'(x3) - DB'(x1);
      dy31 <= DB'(y3) - DB'(y1);
      dx41 <= DB'(x4) - DB'(x1);
      dy41 <= DB'(y4) - DB'(y1);
      dx43 <= DB'(x4) - DB'(x3);
      dy43 <= DB'(y4) - DB'(y3);
      dx13 <= DB'(x1) - DB'(x3);
      dy13 <= DB'(y1) - DB'(y3);
      dx23 <= DB'(x2) - DB'(x3);
      dy23 <= DB'(y2) - DB'(y3);
      s1x3 <= x3;
      s1y3 <= y3;
      s1x4 <= x4;
      s1y4 <= y4;

      box2 <= box1;
      p3a  <= PB'(dx21) * PB'(dy31);
      p3b  <= PB'(dy21) * PB'(dx31);
      p4a  <= PB'(dx21) * PB'(dy41);
      p4b  <= PB'(dy21) * PB'(dx41);
      pe1a <= PB'(dx23) * PB'(dy43);
      pe1b <= PB'(dy23) * PB'(dx43);
      pe2a <= PB'(dx43) * PB'(dy13);
      pe2b <= PB'(dy43) * PB'(dx13);
      s2x3 <= s1x3;
      s2y3 <= s1y3;
      s2x4 <= s1x4;
      s2y4 <= s1y4;

      ctl.meets       <= box2 && st1 && st2;
      ctl.point_valid <= 1'b0;
      a3  <= c3[XB-1] ? AB'(-c3) : AB'(c3);
      a4  <= c4[XB-1] ? AB'(-c4) : AB'(c4);
      bx3 <= s2x3;
      by3 <= s2y3;
      bx4 <= s2x4;
      by4 <= s2y4;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/sgi_weigh.sv =====
// ---------------------------------------------------------------------------
// Segment intersection weighting stages
// Two stages: area-weighted coordinates and denominator, then numerator
// sums split into sign and magnitude.
// ---------------------------------------------------------------------------
`default_nettype none

module sgi_weigh (
  input  wire                                       clk,
  input  wire                                       rst,
  input  wire                                       en,
  input  sgi_pkg::sgi_ctl_t                         ctl_in,
  input  wire logic [sgi_pkg::AB-1:0]               a3,
  input  wire logic [sgi_pkg::AB-1:0]               a4,
  input  wire logic signed [sgi_pkg::COORD_BITS-1:0] x3,
  input  wire logic signed [sgi_pkg::COORD_BITS-1:0] y3,
  input  wire logic signed [sgi_pkg::COORD_BITS-1:0] x4,
  input  wire logic signed [sgi_pkg::COORD_BITS-1:0] y4,
  output sgi_pkg::sgi_ctl_t                         ctl,
  output logic [sgi_pkg::NB-1:0]                    mag_x,
  output logic [sgi_pkg::NB-1:0]                    mag_y,
  output logic                                      neg_x,
  output logic                                      neg_y,
  output logic [sgi_pkg::DNB-1:0]                   den
);
  import sgi_pkg::*;

  sgi_ctl_t              ctl4;
  logic signed [WB-1:0]  px3, px4, py3, py4;
  logic [DNB-1:0]        den4;
  logic signed [NB-1:0]  nx, ny;

  always_comb begin
    nx = NB'(px3) + NB'(px4);
    ny = NB'(py3) + NB'(py4);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl4.valid <= 1'b0;
      ctl.valid  <= 1'b0;
    end else if (en) begin
      ctl4.valid <= ctl_in.valid;
      ctl.valid  <= ctl4.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl4.meets       <= ctl_in.meets;
      ctl4.point_valid <= ctl_in.point_valid;
      px3  <= WB'($signed({1'b0, a4})) * WB'(x3);
      px4  <= WB'($signed({1'b0, a3})) * WB'(x4);
      py3  <= WB'($signed({1'b0, a4})) * WB'(y3);
      py4  <= WB'($signed({1'b0, a3})) * WB'(y4);
      den4 <= DNB'(a3) + DNB'(a4);

      ctl.meets       <= ctl4.meets;
      ctl.point_valid <= (den4 != '0);
      neg_x <= nx[NB-1];
      neg_y <= ny[NB-1];
      mag_x <= nx[NB-1] ? NB'(-nx) : NB'(nx);
      mag_y <= ny[NB-1] ? NB'(-ny) : NB'(ny);
      den   <= den4;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/sgi_div.sv =====
// ---------------------------------------------------------------------------
// Segment intersection divider
// Restoring division pipeline, one quotient bit per stage, both axes side
// by side against a shared denominator.
// ---------------------------------------------------------------------------
`default_nettype none

module sgi_div (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          en,
  input  sgi_pkg::sgi_ctl_t            ctl_in,
  input  wire logic [sgi_pkg::NB-1:0]  mag_x,
  input  wire logic [sgi_pkg::NB-1:0]  mag_y,
  input  wire logic                    neg_x,
  input  wire logic                    neg_y,
  input  wire logic [sgi_pkg::DNB-1:0] den,
  output sgi_pkg::sgi_ctl_t            ctl,
  output logic [sgi_pkg::QB-1:0]       quo_x,
  output logic [sgi_pkg::QB-1:0]       quo_y,
  output logic                         sgn_x,
  output logic                         sgn_y
);
  import sgi_pkg::*;

  sgi_ctl_t        sc  [QB+1];
  logic [RB-1:0]   rx  [QB+1];
  logic [RB-1:0]   ry  [QB+1];
  logic [DNB-1:0]  dv  [QB+1];
  logic [QB-1:0]   qx  [QB+1];
  logic [QB-1:0]   qy  [QB+1];
  logic            nx  [QB+1];
  logic            ny  [QB+1];

  always_comb begin
    sc[0] = ctl_in;
    rx[0] = RB'(mag_x);
    ry[0] = RB'(mag_y);
    dv[0] = den;
    qx[0] = '0;
    qy[0] = '0;
    nx[0] = neg_x;
    ny[0] = neg_y;
  end

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic [RB-1:0] dsh;
    logic          tx, ty;

    always_comb begin
      dsh = RB'(dv[k]) << (QB - 1 - k);
      tx  = (rx[k] >= dsh);
      ty  = (ry[k] >= dsh);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sc[k+1].valid <= 1'b0;
      end else if (en) begin
        sc[k+1].valid <= sc[k].valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sc[k+1].meets       <= sc[k].meets;
        sc[k+1].point_valid <= sc[k].point_valid;
        rx[k+1] <= tx ? rx[k] - dsh : rx[k];
        ry[k+1] <= ty ? ry[k] - dsh : ry[k];
        qx[k+1] <= qx[k] | (QB'(tx) << (QB - 1 - k));
        qy[k+1] <= qy[k] | (QB'(ty) << (QB - 1 - k));
        dv[k+1] <= dv[k];
        nx[k+1] <= nx[k];
        ny[k+1] <= ny[k];
      end
    end
  end

  assign ctl   = sc[QB];
  assign quo_x = qx[QB];
  assign quo_y = qy[QB];
  assign sgn_x = nx[QB];
  assign sgn_y = ny[QB];

endmodule

`default_nettype wire

// ===== hdl/segment_intersection.sv =====
// Pipeline: 3 cross-product stages, 2 weighting stages, 17 divider stages and
// 1 output register lie between an accepted item and its result.
// Throughput: one item per cycle; the whole pipeline advances together and
// holds while a result waits at the output.
// Reset: synchronous, active high; clears all valid bits, drops items in flight.
// ---------------------------------------------------------------------------
// Segment intersection
// Pipelined test whether two closed segments meet, with their intersection
// point by exact integer arithmetic.
// ---------------------------------------------------------------------------
`default_nettype none

module segment_intersection (
  input  wire                                       clk,
  input  wire                                       rst,
  input  wire                                       in_valid,
  output logic                                      in_ready,
  input  wire logic signed [sgi_pkg::COORD_BITS-1:0] a_start_x,
  input  wire logic signed [sgi_pkg::COORD_BITS-1:0] a_start_y,
  input  wire logic signed [sgi_pkg::COORD_BITS-1:0] a_end_x,
  input  wire logic signed [sgi_pkg::COORD_BITS-1:0] a_end_y,
  input  wire logic signed [sgi_pkg::COORD_BITS-1:0] b_start_x,
  input  wire logic signed [sgi_pkg::COORD_BITS-1:0] b_start_y,
  input  wire logic signed [sgi_pkg::COORD_BITS-1:0] b_end_x,
  input  wire logic signed [sgi_pkg::COORD_BITS-1:0] b_end_y,
  output logic                                      out_valid,
  input  wire                                       out_ready,
  output logic                                      meets,
  output logic                                      point_valid,
  output logic signed [sgi_pkg::COORD_BITS-1:0]     cross_x,
  output logic signed [sgi_pkg::COORD_BITS-1:0]     cross_y
);
  import sgi_pkg::*;

  logic                          en;
  sgi_ctl_t                      ctl_c, ctl_w, ctl_d;
  logic [AB-1:0]                 a3, a4;
  logic signed [COORD_BITS-1:0]  bx3, by3, bx4, by4;
  logic [NB-1:0]                 mag_x, mag_y;
  logic                          neg_x, neg_y;
  logic [DNB-1:0]                den;
  logic [QB-1:0]                 quo_x, quo_y;
  logic                          sgn_x, sgn_y;
  logic [QB-1:0]                 sx, sy;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  sgi_cross u_cross (
    .clk(clk), .rst(rst), .en(en), .in_valid(in_valid),
    .x1(a_start_x), .y1(a_start_y), .x2(a_end_x), .y2(a_end_y),
    .x3(b_start_x), .y3(b_start_y), .x4(b_end_x), .y4(b_end_y),
    .ctl(ctl_c), .a3(a3), .a4(a4),
    .bx3(bx3), .by3(by3), .bx4(bx4), .by4(by4)
  );

  sgi_weigh u_weigh (
    .clk(clk), .rst(rst), .en(en), .ctl_in(ctl_c), .a3(a3), .a4(a4),
    .x3(bx3), .y3(by3), .x4(bx4), .y4(by4),
    .ctl(ctl_w), .mag_x(mag_x), .mag_y(mag_y),
    .neg_x(neg_x), .neg_y(neg_y), .den(den)
  );

  sgi_div u_div (
    .clk(clk), .rst(rst), .en(en), .ctl_in(ctl_w),
    .mag_x(mag_x), .mag_y(mag_y), .neg_x(neg_x), .neg_y(neg_y), .den(den),
    .ctl(ctl_d), .quo_x(quo_x), .quo_y(quo_y), .sgn_x(sgn_x), .sgn_y(sgn_y)
  );

  always_comb begin
    sx = sgn_x ? QB'(-quo_x) : quo_x;
    sy = sgn_y ? QB'(-quo_y) : quo_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= ctl_d.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      meets       <= ctl_d.meets;
      point_valid <= ctl_d.point_valid;
      cross_x     <= ctl_d.point_valid ? sx[COORD_BITS-1:0] : '0;
      cross_y     <= ctl_d.point_valid ? sy[COORD_BITS-1:0] : '0;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/sgi_checker.sv =====
// ---------------------------------------------------------------------------
// Segment intersection port checker
// Watches the top-level ports for handshake and result consistency.
// ---------------------------------------------------------------------------
`default_nettype none

`include "segment_intersection_defines.svh"

module sgi_checker (
  input wire                                       clk,
  input wire                                       rst,
  input wire                                       in_ready,
  input wire                                       out_valid,
  input wire                                       out_ready,
  input wire                                       meets,
  input wire                                       point_valid,
  input wire logic signed [sgi_pkg::COORD_BITS-1:0] cross_x,
  input wire logic signed [sgi_pkg::COORD_BITS-1:0] cross_y
);
  import sgi_pkg::*;

  `SGI_ASSERT(a_hold, out_valid && !out_ready |=> out_valid && $stable(cross_x) && $stable(cross_y) && $stable(meets), "stalled result changed")
  `SGI_ASSERT(a_zero_point, out_valid && !point_valid |-> cross_x == '0 && cross_y == '0, "collinear point not zero")
  `SGI_ASSERT(a_ready, in_ready == (!out_valid || out_ready), "input ready does not follow output")
  `SGI_ASSERT_ALWAYS(a_reset, $past(rst) |-> !out_valid, "result valid after reset")

endmodule

bind segment_intersection sgi_checker u_sgi_checker (
  .clk(clk), .rst(rst), .in_ready(in_ready), .out_valid(out_valid),
  .out_ready(out_ready), .meets(meets), .point_valid(point_valid),
  .cross_x(cross_x), .cross_y(cross_y)
);

`default_nettype wire
